/* rtl/array_range_reduce_sampler_macros.svh */
// ============================================================================
// array_range_reduce_sampler_macros.svh
// Assertion shorthands shared by the sampler RTL.
// ============================================================================
`ifndef ARRAY_RANGE_REDUCE_SAMPLER_MACROS_SVH
`define ARRAY_RANGE_REDUCE_SAMPLER_MACROS_SVH

// Clocked check, off while reset is asserted (active-low reset).
`define ARRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ARRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/arrs_pkg.sv */
// ============================================================================
// arrs_pkg
// Types, codes and constants of the array range reduce / sampler block.
// ============================================================================
package arrs_pkg;

    // Default sizes
    localparam int ARRAY_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // Field widths
    localparam int OP_W      = 3;
    localparam int START_W   = 10;
    localparam int COUNT_W   = 12;
    localparam int ELEM_W    = 24;
    localparam int FRAC_W    = 33;
    localparam int SEED_W    = 32;
    localparam int VALUE_W   = 34;
    localparam int INDEX_W   = 10;
    localparam int LEN_CFG_W = 11;

    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 11'd100;

    // Generator constants
    localparam logic [31:0] LCG_MUL = 32'd472940017;
    localparam logic [31:0] LCG_ADD = 32'd832416023;
    localparam logic [63:0] GEN_SEED_FULL = 64'd584926371 * 64'd435898247 + 64'd938284287;
    localparam logic [31:0] GEN_RESET = GEN_SEED_FULL[31:0];

    // Result value limits
    localparam logic signed [63:0] VALUE_MAX_64 = 64'sd8589934591;
    localparam logic signed [63:0] VALUE_MIN_64 = -64'sd8589934592;
    localparam logic [VALUE_W-1:0] VALUE_MAX_34 = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN_34 = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_SUM   = 3'd1,
        OP_MAX   = 3'd2,
        OP_MIN   = 3'd3,
        OP_QUANT = 3'd4,
        OP_RAND  = 3'd5,
        OP_SEED  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_THRESH,
        S_WALK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_HI,
        TP_SUM,
        TP_DONE
    } t_thr_phase;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [START_W-1:0]        range_start;
        logic signed [COUNT_W-1:0] range_count;
        logic signed [ELEM_W-1:0]  element_value;
        logic [FRAC_W-1:0]         quantile_fraction;
        logic [SEED_W-1:0]         seed_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [INDEX_W-1:0]        result_index;
    } t_rsp;

endpackage

/* rtl/arrs_ram.sv */
// ============================================================================
// arrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module arrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/arrs_lcg.sv */
// ============================================================================
// arrs_lcg
// 32-bit linear congruential generator state with step and load.
// ============================================================================
module arrs_lcg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_load,
    input  logic [31:0] i_seed,
    output logic [31:0] o_next
);
    import arrs_pkg::*;

    logic [31:0] r_gen;
    logic [31:0] n_gen;
    logic [31:0] w_step;

    // x' = x * MUL + ADD, low 32 bits only
    assign w_step = r_gen * LCG_MUL + LCG_ADD;
    assign o_next = w_step;

    always_comb begin
        n_gen = r_gen;
        if (i_load) begin
            n_gen = i_seed;
        end else if (i_step) begin
            n_gen = w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_RESET;
        end else begin
            r_gen <= n_gen;
        end
    end

endmodule

/* rtl/arrs_thresh.sv */
// ============================================================================
// arrs_thresh
// Quantile threshold floor(total * frac / 2^32), split into partial products
// that are registered in the start, HI and SUM phases.
// ============================================================================
module arrs_thresh #(
    parameter int ACC_W = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ACC_W-1:0]              i_total,
    input  logic [arrs_pkg::FRAC_W-1:0]   i_frac,
    output logic                          o_done,
    output logic [ACC_W-1:0]              o_thr
);
    import arrs_pkg::*;

    t_thr_phase  r_phase;
    t_thr_phase  n_phase;

    logic [63:0] w_tot64;
    logic [31:0] w_tl;
    logic [15:0] w_th;
    logic [31:0] w_fl;
    logic        w_fh;
    logic [63:0] w_mlo;
    logic [47:0] w_mhi;
    logic [63:0] w_sum;

    logic [31:0]      r_mlo_hi;
    logic [47:0]      r_mhi;
    logic [ACC_W-1:0] r_thr;

    // Operand split; total is at most 48 bits wide
    assign w_tot64 = 64'(i_total);
    assign w_tl    = w_tot64[31:0];
    assign w_th    = w_tot64[47:32];
    assign w_fl    = i_frac[31:0];
    assign w_fh    = i_frac[32];

    assign w_mlo = w_tl * w_fl;
    assign w_mhi = w_th * w_fl;
    assign w_sum = (w_fh ? w_tot64 : 64'd0) + {16'd0, r_mhi} + {32'd0, r_mlo_hi};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            TP_IDLE: if (i_start) n_phase = TP_HI;
            TP_HI:   n_phase = TP_SUM;
            TP_SUM:  n_phase = TP_DONE;
            TP_DONE: n_phase = TP_IDLE;
            default: n_phase = TP_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = (r_phase == TP_DONE);
        o_thr  = r_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= TP_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Partial products, each registered in its own phase
    always_ff @(posedge i_clk) begin
        if (r_phase == TP_IDLE && i_start) begin
            r_mlo_hi <= w_mlo[63:32];
        end
        if (r_phase == TP_HI) begin
            r_mhi <= w_mhi;
        end
        if (r_phase == TP_SUM) begin
            r_thr <= w_sum[ACC_W-1:0];
        end
    end

endmodule

/* rtl/array_range_reduce_sampler.sv */
// Sum/max/min: one element read per cycle through the single sample RAM read
//   port over the clamped range. Quantile/random: two RAM passes plus a
//   threshold multiply. Write, seed and unused codes give no result.
// Results are one-cycle strobes, the receiver cannot stall. After reset the
//   RAM is zeroed while busy.
// ============================================================================
// array_range_reduce_sampler
// Sample array with range sum / max / min, quantile and random draw.
// ============================================================================
`include "array_range_reduce_sampler_macros.svh"

module array_range_reduce_sampler #(
    parameter int ARRAY_DEPTH = arrs_pkg::ARRAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = arrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [arrs_pkg::LEN_CFG_W-1:0]   i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  arrs_pkg::t_req                   i_req,
    output logic                             o_result_valid,
    output arrs_pkg::t_rsp                   o_rsp
);
    import arrs_pkg::*;

    localparam int AW    = $clog2(ARRAY_DEPTH);
    localparam int LEN_W = $clog2(ARRAY_DEPTH + 1);
    localparam int ACC_W = SAMPLE_BITS + $clog2(ARRAY_DEPTH);

    // Control state
    t_state                r_state, n_state;
    logic [LEN_CFG_W-1:0]  r_len;
    logic [LEN_W-1:0]      r_cnt, n_cnt;
    logic                  r_rd_vld;
    logic [LEN_W-1:0]      r_rd_idx;

    // Request and reduction registers
    t_op                   r_op, n_op;
    logic [LEN_W-1:0]      r_first, n_first;
    logic [LEN_W-1:0]      r_n, n_n;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [SAMPLE_BITS-1:0] r_best, n_best;
    logic [LEN_W-1:0]      r_best_i, n_best_i;
    logic [LEN_W-1:0]      r_ans, n_ans;
    logic [FRAC_W-1:0]     r_frac, n_frac;

    // Combinational
    logic                  w_accept;
    logic [LEN_W-1:0]      w_len;
    logic [LEN_W-1:0]      w_first;
    logic [LEN_W-1:0]      w_rem;
    logic [LEN_W-1:0]      w_n;
    logic                  w_wr_ok;
    logic [31:0]           w_ev32;
    logic [LEN_W-1:0]      w_walk_lim;
    logic [LEN_W-1:0]      w_lim;
    logic                  w_pass_end;
    logic                  w_issue;
    logic                  w_quant;
    logic                  w_hit;
    logic                  w_thr_start;
    logic                  w_thr_done;
    logic [ACC_W-1:0]      w_thr;
    logic [LEN_W-1:0]      w_raddr_full;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic [ACC_W-1:0]      w_v_sext;
    logic [ACC_W-1:0]      w_v_pos;
    logic [ACC_W-1:0]      w_pacc;
    logic [LEN_W-1:0]      w_best_abs;
    logic [VALUE_W-1:0]    w_best34;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [SAMPLE_BITS-1:0] w_ram_wdata;
    logic [31:0]           w_lcg_next;
    logic                  w_lcg_step;
    logic                  w_lcg_load;

    // Saturate the sum to the result field
    function automatic logic [VALUE_W-1:0] sat_value(input logic [ACC_W-1:0] acc);
        logic signed [63:0] v;
        v = $signed({{(64-ACC_W){acc[ACC_W-1]}}, acc});
        if (v > VALUE_MAX_64) begin
            return VALUE_MAX_34;
        end else if (v < VALUE_MIN_64) begin
            return VALUE_MIN_34;
        end
        return v[VALUE_W-1:0];
    endfunction

    // Range clamping at request time
    always_comb begin
        if (32'(r_len) > 32'(ARRAY_DEPTH)) begin
            w_len = LEN_W'(ARRAY_DEPTH);
        end else begin
            w_len = LEN_W'(r_len);
        end
        if (32'(i_req.range_start) > 32'(w_len)) begin
            w_first = w_len;
        end else begin
            w_first = LEN_W'(i_req.range_start);
        end
        w_rem = w_len - w_first;
        if (i_req.range_count[COUNT_W-1] ||
            32'($unsigned(i_req.range_count)) > 32'(w_rem)) begin
            w_n = w_rem;
        end else begin
            w_n = LEN_W'($unsigned(i_req.range_count));
        end
        w_wr_ok = 32'(i_req.range_start) < 32'(w_len);
        w_ev32  = {{(32-ELEM_W){i_req.element_value[ELEM_W-1]}}, i_req.element_value};
    end

    // Pass limits and sample decode
    assign w_quant      = (r_op == OP_QUANT) || (r_op == OP_RAND);
    assign w_walk_lim   = (r_n == '0) ? '0 : r_n - 1'b1;
    assign w_lim        = (r_state == S_WALK) ? w_walk_lim : r_n;
    assign w_pass_end   = (r_cnt == w_lim) && !r_rd_vld;
    assign w_raddr_full = r_first + r_cnt;
    assign w_v_sext     = {{(ACC_W-SAMPLE_BITS){w_rdata[SAMPLE_BITS-1]}}, w_rdata};
    assign w_v_pos      = (w_rdata[SAMPLE_BITS-1] || w_rdata == '0) ? '0 : ACC_W'(w_rdata);
    assign w_pacc       = r_acc + w_v_pos;
    assign w_hit        = (r_state == S_WALK) && r_rd_vld && (w_pacc > w_thr);
    assign w_best_abs   = r_first + r_best_i;
    assign w_best34     = {{(VALUE_W-SAMPLE_BITS){r_best[SAMPLE_BITS-1]}}, r_best};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == LEN_W'(ARRAY_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start && (i_req.operation == OP_SUM || i_req.operation == OP_MAX ||
                              i_req.operation == OP_MIN || i_req.operation == OP_QUANT ||
                              i_req.operation == OP_RAND)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_pass_end) n_state = w_quant ? S_THRESH : S_DONE;
            end
            S_THRESH: begin
                if (w_thr_done) n_state = S_WALK;
            end
            S_WALK: begin
                if (w_hit || w_pass_end) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and control strobes
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_result_valid = (r_state == S_DONE);
        w_accept       = (r_state == S_IDLE) && start;
        w_issue        = (r_state == S_SCAN || r_state == S_WALK) && (r_cnt != w_lim);
        w_thr_start    = (r_state == S_SCAN) && w_pass_end && w_quant;
        w_lcg_step     = w_accept && (i_req.operation == OP_RAND);
        w_lcg_load     = w_accept && (i_req.operation == OP_SEED);

        // RAM write: clearing sweep or a write request
        if (r_state == S_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_cnt[AW-1:0];
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_accept && (i_req.operation == OP_WRITE) && w_wr_ok;
            w_ram_waddr = AW'(i_req.range_start);
            w_ram_wdata = w_ev32[SAMPLE_BITS-1:0];
        end

        // Result payload
        o_rsp.result_value = '0;
        o_rsp.result_index = '0;
        case (r_op)
            OP_SUM: begin
                o_rsp.result_value = sat_value(r_acc);
            end
            OP_MAX: begin
                o_rsp.result_value = (r_n == '0) ? VALUE_MIN_34 : w_best34;
                o_rsp.result_index = INDEX_W'(w_best_abs);
            end
            OP_MIN: begin
                o_rsp.result_value = (r_n == '0) ? VALUE_MAX_34 : w_best34;
                o_rsp.result_index = INDEX_W'(w_best_abs);
            end
            default: begin
                o_rsp.result_index = INDEX_W'(r_ans);
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_first  = r_first;
        n_n      = r_n;
        n_acc    = r_acc;
        n_best   = r_best;
        n_best_i = r_best_i;
        n_ans    = r_ans;
        n_frac   = r_frac;
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_op     = t_op'(i_req.operation);
                    n_first  = w_first;
                    n_n      = w_n;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_best   = '0;
                    n_best_i = '0;
                    n_frac   = (i_req.operation == OP_RAND) ? {1'b0, w_lcg_next}
                                                            : i_req.quantile_fraction;
                end
            end
            S_SCAN: begin
                if (w_issue) n_cnt = r_cnt + 1'b1;
                if (r_rd_vld) begin
                    case (r_op)
                        OP_SUM: n_acc = r_acc + w_v_sext;
                        OP_MAX: begin
                            if (r_rd_idx == '0 ||
                                $signed(w_rdata) > $signed(r_best)) begin
                                n_best   = w_rdata;
                                n_best_i = r_rd_idx;
                            end
                        end
                        OP_MIN: begin
                            if (r_rd_idx == '0 ||
                                $signed(w_rdata) < $signed(r_best)) begin
                                n_best   = w_rdata;
                                n_best_i = r_rd_idx;
                            end
                        end
                        default: n_acc = w_pacc;
                    endcase
                end
            end
            S_THRESH: begin
                if (w_thr_done) begin
                    n_cnt = '0;
                    n_acc = '0;
                    n_ans = w_walk_lim;
                end
            end
            S_WALK: begin
                if (w_issue) n_cnt = r_cnt + 1'b1;
                if (r_rd_vld) n_acc = w_pacc;
                if (w_hit) n_ans = r_rd_idx;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_len    <= LEN_RESET;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= w_issue;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        r_op     <= n_op;
        r_first  <= n_first;
        r_n      <= n_n;
        r_acc    <= n_acc;
        r_best   <= n_best;
        r_best_i <= n_best_i;
        r_ans    <= n_ans;
        r_frac   <= n_frac;
    end

    // Sample store
    arrs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ARRAY_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_raddr_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Random generator
    arrs_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_lcg_step),
        .i_load  (w_lcg_load),
        .i_seed  (i_req.seed_value),
        .o_next  (w_lcg_next)
    );

    // Quantile threshold
    arrs_thresh #(
        .ACC_W (ACC_W)
    ) u_thresh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_thr_start),
        .i_total (r_acc),
        .i_frac  (r_frac),
        .o_done  (w_thr_done),
        .o_thr   (w_thr)
    );

    // Checks
    `ARRS_ASSERT(a_res_while_busy, i_clk, i_rst_n, o_result_valid |-> busy, "result strobe while idle")
    `ARRS_ASSERT(a_res_one_cycle, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "result strobe longer than one cycle")
    `ARRS_ASSERT(a_quiet_ops, i_clk, i_rst_n, (start && !busy && (i_req.operation == OP_WRITE || i_req.operation == OP_SEED)) |=> !busy, "write or seed left block busy")
    `ARRS_ASSERT(a_reduce_busy, i_clk, i_rst_n, (start && !busy && (i_req.operation == OP_SUM || i_req.operation == OP_QUANT || i_req.operation == OP_RAND)) |=> busy, "reduce request not taken")
    `ARRS_ASSERT(a_read_in_range, i_clk, i_rst_n, w_issue |-> (w_raddr_full < LEN_W'(ARRAY_DEPTH)), "sample read beyond depth")

endmodule

/* tb/sv/array_range_reduce_sampler_tb.sv */
// ============================================================================
// array_range_reduce_sampler_tb
// Self-checking bench for the sample array reduce / quantile / draw block.
// A directed table covers the empty array after reset, extreme samples,
// range clamping, empty ranges, the generator and ignored codes. Random
// phases follow, one per array length. Every request is mirrored into a
// local copy of the sample store, generator and length, and each result
// strobe is checked field by field against the oldest prediction.
// ============================================================================
module array_range_reduce_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arrs_pkg::*;

    localparam int DEPTH       = ARRAY_DEPTH_DEF;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 64;
    localparam int STALL_LIMIT = 25000;
    localparam int PHASE_ITEMS = 44;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [ELEM_W-1:0]  ELEM_MAX   = 24'sh7FFFFF;
    localparam logic signed [ELEM_W-1:0]  ELEM_MIN   = 24'sh800000;
    localparam logic signed [VALUE_W-1:0] RESULT_MAX = 34'sh1FFFFFFFF;
    localparam logic signed [VALUE_W-1:0] RESULT_MIN = 34'sh200000000;
    localparam longint                    SUM_MAX    = 64'sd8589934591;
    localparam longint                    SUM_MIN    = -64'sd8589934592;
    localparam logic [63:0]               FRAC_ONE   = 64'h1_0000_0000;

    // generator: x = x * GEN_MUL + GEN_ADD, reset value fixed
    localparam logic [31:0] GEN_MUL  = 32'd472940017;
    localparam logic [31:0] GEN_ADD  = 32'd832416023;
    localparam logic [63:0] GEN_PROD = 64'd584926371 * 64'd435898247 + 64'd938284287;
    localparam logic [31:0] GEN_INIT = GEN_PROD[31:0];

    typedef struct {
        bit                   is_cfg;
        bit                   typed;
        t_req                 req;
        logic [LEN_CFG_W-1:0] len;
        t_rsp                 want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [LEN_CFG_W-1:0] i_cfg_wdata;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_result_valid;
    t_rsp                 o_rsp;

    // mirror of the block state
    logic signed [ELEM_W-1:0] sample_mirror [DEPTH];
    logic [31:0]              gen_mirror;
    logic [LEN_CFG_W-1:0]     length_mirror;

    t_rsp awaited_rsp [$];
    t_row plan [$];
    int   mismatch_count = 0;
    int   stall_cycles = 0;
    int   burst_left = 0;

    always #6 i_clk = ~i_clk;

    array_range_reduce_sampler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_rsp          (o_rsp)
    );

    // relative index where the positive running sum first passes frac * total
    function automatic int quantile_index(input int first, input int n,
                                          input logic [32:0] frac);
        logic [63:0] total;
        logic [63:0] run;
        logic [97:0] prod;
        logic [65:0] thr;
        int          i;
        total = '0;
        run   = '0;
        for (i = 0; i < n; i++) begin
            if (sample_mirror[first + i] > 0) total += sample_mirror[first + i];
        end
        prod = {34'd0, total} * {65'd0, frac};
        thr  = prod[97:32];
        if (n == 0) return 0;
        for (i = 0; i + 1 < n; i++) begin
            if (sample_mirror[first + i] > 0) run += sample_mirror[first + i];
            if ({2'b00, run} > thr) break;
        end
        return i;
    endfunction

    // apply one request to the mirror; returns 1 when it yields a result
    function automatic bit evaluate_command(input t_req r, output t_rsp rsp);
        int     span;
        int     first;
        int     n;
        int     cnt;
        int     i;
        int     pick;
        longint acc;
        longint best;
        longint v;
        rsp  = '0;
        span = (length_mirror > DEPTH) ? DEPTH : int'(length_mirror);
        if (r.operation == OP_WRITE) begin
            if (r.range_start < span) sample_mirror[r.range_start] = r.element_value;
            return 1'b0;
        end
        if (r.operation == OP_SEED) begin
            gen_mirror = r.seed_value;
            return 1'b0;
        end
        if (r.operation == OP_UNUSED) return 1'b0;

        // clamp the range to the live array
        first = (r.range_start > span) ? span : int'(r.range_start);
        cnt   = int'(r.range_count);
        n     = (cnt < 0 || cnt > span - first) ? span - first : cnt;

        if (r.operation == OP_SUM) begin
            acc = 0;
            for (i = 0; i < n; i++) acc += sample_mirror[first + i];
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < SUM_MIN) acc = SUM_MIN;
            rsp.result_value = acc[VALUE_W-1:0];
        end else if (r.operation == OP_MAX || r.operation == OP_MIN) begin
            best = (r.operation == OP_MAX) ? SUM_MIN : SUM_MAX;
            pick = 0;
            for (i = 0; i < n; i++) begin
                v = sample_mirror[first + i];
                if (i == 0 || (r.operation == OP_MAX && v > best)
                           || (r.operation == OP_MIN && v < best)) begin
                    best = v;
                    pick = i;
                end
            end
            rsp.result_value = best[VALUE_W-1:0];
            rsp.result_index = INDEX_W'(first + pick);
        end else if (r.operation == OP_QUANT) begin
            rsp.result_index = INDEX_W'(quantile_index(first, n, r.quantile_fraction));
        end else begin
            gen_mirror       = gen_mirror * GEN_MUL + GEN_ADD;
            rsp.result_index = INDEX_W'(quantile_index(first, n, {1'b0, gen_mirror}));
        end
        return 1'b1;
    endfunction

    // random request; mostly in-range starts and short ranges
    function automatic t_req random_command(input int span);
        t_req r;
        int   pick;
        r.range_start       = START_W'($urandom);
        r.range_count       = COUNT_W'($urandom);
        r.element_value     = ELEM_W'($urandom);
        r.quantile_fraction = {1'b0, $urandom()};
        r.seed_value        = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.operation = OP_WRITE;
        else if (pick < 50) r.operation = OP_SUM;
        else if (pick < 60) r.operation = OP_MAX;
        else if (pick < 70) r.operation = OP_MIN;
        else if (pick < 82) r.operation = OP_QUANT;
        else if (pick < 94) r.operation = OP_RAND;
        else if (pick < 98) r.operation = OP_SEED;
        else                r.operation = OP_UNUSED;
        if ($urandom_range(0, 9) != 0) r.range_start = START_W'($urandom_range(0, span - 1));
        pick = $urandom_range(0, 9);
        if (pick < 7)       r.range_count = COUNT_W'($urandom_range(0, 12));
        else if (pick == 7) r.range_count = COUNT_W'(-1);
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.element_value = ELEM_MAX;
        else if (pick == 1) r.element_value = ELEM_MIN;
        else if (pick < 6)  r.element_value = ELEM_W'($urandom_range(0, 4000) - 2000);
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.quantile_fraction = '0;
        else if (pick == 1) r.quantile_fraction = FRAC_ONE[32:0];
        return r;
    endfunction

    // table rows: one request, a request with a fixed answer, a length write
    function automatic void add_cmd(input logic [OP_W-1:0] op, input int start_at,
                                    input int count, input logic [63:0] val);
        t_row row;
        row                       = '{default: '0};
        row.req.operation         = op;
        row.req.range_start       = START_W'(start_at);
        row.req.range_count       = COUNT_W'(count);
        row.req.element_value     = val[ELEM_W-1:0];
        row.req.quantile_fraction = val[FRAC_W-1:0];
        row.req.seed_value        = val[SEED_W-1:0];
        plan.push_back(row);
    endfunction

    function automatic void add_check(input logic [OP_W-1:0] op, input int start_at,
                                      input int count, input logic [63:0] val,
                                      input logic signed [VALUE_W-1:0] want_value,
                                      input int want_index);
        add_cmd(op, start_at, count, val);
        plan[$].typed                  = 1'b1;
        plan[$].want.result_value      = want_value;
        plan[$].want.result_index      = INDEX_W'(want_index);
    endfunction

    function automatic void add_length(input int len);
        t_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.len    = LEN_CFG_W'(len);
        plan.push_back(row);
    endfunction

    // sender bursts with random gaps between them
    task automatic next_slot();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40)
                                                     : $urandom_range(1, 6);
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        burst_left--;
    endtask

    // hold the request until it is taken, then predict its result
    task automatic send(input t_req r, input bit typed, input t_rsp want);
        t_rsp predicted;
        bit   yields;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        yields = evaluate_command(r, predicted);
        if (yields) awaited_rsp.push_back(typed ? want : predicted);
    endtask

    // length write once the block has drained
    task automatic apply_length(input logic [LEN_CFG_W-1:0] len);
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_rsp.size() != 0 || busy);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        length_mirror  = len;
        burst_left     = 0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (awaited_rsp.size() == 0) begin
                $display("%0t: unexpected result: value %0d index %0d",
                         $time, o_rsp.result_value, o_rsp.result_index);
                mismatch_count++;
            end else begin
                if (o_rsp.result_value !== awaited_rsp[0].result_value) begin
                    $display("%0t: result_value mismatch: expected %0d, actual %0d",
                             $time, awaited_rsp[0].result_value, o_rsp.result_value);
                    mismatch_count++;
                end
                if (o_rsp.result_index !== awaited_rsp[0].result_index) begin
                    $display("%0t: result_index mismatch: expected %0d, actual %0d",
                             $time, awaited_rsp[0].result_index, o_rsp.result_index);
                    mismatch_count++;
                end
                void'(awaited_rsp.pop_front());
            end
        end
    end

    // watchdog on cycles with no request or result taken
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int   phase_len [6];
        t_rsp no_rsp;
        no_rsp        = '0;
        foreach (sample_mirror[k]) sample_mirror[k] = '0;
        gen_mirror    = GEN_INIT;
        length_mirror = LEN_RESET;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        start       <= 1'b0;
        i_req       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty array after reset, empty and clamped ranges
        add_check(OP_SUM,   0,    -1, 0, 0, 0);
        add_check(OP_MAX,   0,    -1, 0, 0, 0);
        add_check(OP_MIN,   5,     0, 0, RESULT_MAX, 5);
        add_check(OP_MAX,   1023,  4, 0, RESULT_MIN, 100);
        add_cmd(OP_QUANT,   0,    -1, FRAC_ONE);
        // extreme samples; writes at and past the length are dropped
        add_cmd(OP_WRITE,   0,     0, ELEM_MAX);
        add_cmd(OP_WRITE,   99,    0, ELEM_MIN);
        add_cmd(OP_WRITE,   100,   0, 5);
        add_cmd(OP_WRITE,   50,    0, 1000);
        add_cmd(OP_WRITE,   52,    0, 600);
        add_check(OP_MAX,   0,    -1, 0, ELEM_MAX, 0);
        add_check(OP_MIN,   0,    -1, 0, ELEM_MIN, 99);
        add_cmd(OP_SUM,     0,  1024, 0);
        add_cmd(OP_SUM,     50, -2048, 0);
        // quantile at fraction zero and one, empty range
        add_cmd(OP_QUANT,   0,    -1, 0);
        add_cmd(OP_QUANT,   50,    3, FRAC_ONE);
        add_check(OP_QUANT, 10,    0, FRAC_ONE, 0, 0);
        // generator from reset, then reseeded
        add_cmd(OP_RAND,    0,    -1, 0);
        add_cmd(OP_SEED,    0,     0, 64'hFFFF_FFFF);
        add_cmd(OP_RAND,    50,    3, 0);
        add_cmd(OP_UNUSED,  1023, -1, '1);
        // full depth, single element, and a length above the depth
        add_length(DEPTH);
        add_cmd(OP_WRITE,   1023,  0, ELEM_MAX);
        add_check(OP_MAX,   100,  -1, 0, ELEM_MAX, 1023);
        add_cmd(OP_QUANT,   0,    -1, 64'h8000_0000);
        add_length(1);
        add_cmd(OP_SUM,     0,    -1, 0);
        add_length(2047);
        add_check(OP_MIN,   0,    -1, 0, ELEM_MIN, 99);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                apply_length(plan[k].len);
            end else begin
                next_slot();
                send(plan[k].req, plan[k].typed, plan[k].want);
            end
        end

        // random phases, one array length each
        phase_len = '{DEPTH, 1, 2047, $urandom_range(2, DEPTH - 1),
                      $urandom_range(1, 16), 100};
        foreach (phase_len[p]) begin
            apply_length(LEN_CFG_W'(phase_len[p]));
            repeat (PHASE_ITEMS) begin
                next_slot();
                send(random_command((phase_len[p] > DEPTH) ? DEPTH : phase_len[p]),
                     1'b0, no_rsp);
            end
        end

        // drain, then watch for stray results
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_rsp.size() != 0);
        repeat (TAIL) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
